// File: design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the bcrypt radix-64
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned SEXTET_W    = 6;
	localparam int unsigned LEFT_W      = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef logic [SEXTET_W-1:0] sextet_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2,
		POS_UNUSED = 2'd3
	} group_pos_t;

	// One classified byte: up to two sextets to emit, and how to flag them.
	typedef struct packed {
		sextet_t sext0;
		sextet_t sext1;
		logic    two;
		logic    last;
	} entry_t;

	// Maps a sextet onto the alphabet "./A-Za-z0-9".
	function automatic logic [CHAR_W-1:0] to_char(input sextet_t s);
		logic [CHAR_W-1:0] ext;
		logic [CHAR_W-1:0] c;
		begin
			ext = {1'b0, s};
			if (s < 6'd2) begin
				c = 7'd46 + ext;
			end else if (s < 6'd28) begin
				c = 7'd63 + ext;
			end else if (s < 6'd54) begin
				c = 7'd69 + ext;
			end else begin
				c = ext - 7'd6;
			end
			return c;
		end
	endfunction

endpackage

`default_nettype wire

// File: design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group position and leftover bits, and turns each
// byte into one queue entry of one or two sextets.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [b64e_pkg::BYTE_W-1:0] in_byte,
	input  wire logic                     in_last,
	input  wire logic                     queue_full,
	output logic                          push,
	output b64e_pkg::entry_t              push_entry
);
	import b64e_pkg::*;

	group_pos_t          pos_q;
	logic [LEFT_W-1:0]   left_q;
	group_pos_t          pos_next;
	logic [LEFT_W-1:0]   left_next;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_entry.last = in_last;
		case (pos_q)
			POS_SECOND: begin
				push_entry.sext0 = {left_q[1:0], in_byte[7:4]};
				push_entry.sext1 = {in_byte[3:0], 2'b00};
				push_entry.two   = in_last;
				pos_next         = POS_THIRD;
				left_next        = in_byte[3:0];
			end
			POS_THIRD: begin
				push_entry.sext0 = {left_q, in_byte[7:6]};
				push_entry.sext1 = in_byte[5:0];
				push_entry.two   = 1'b1;
				pos_next         = POS_FIRST;
				left_next        = '0;
			end
			default: begin
				push_entry.sext0 = in_byte[7:2];
				push_entry.sext1 = {in_byte[1:0], 4'b0000};
				push_entry.two   = in_last;
				pos_next         = POS_SECOND;
				left_next        = {2'b00, in_byte[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_FIRST;
			left_q <= '0;
		end else if (push) begin
			if (in_last) begin
				pos_q  <= POS_FIRST;
				left_q <= '0;
			end else begin
				pos_q  <= pos_next;
				left_q <= left_next;
			end
		end
	end

	a_pos_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != POS_UNUSED)
		else $error("group position reached an unused code");

	a_left_first: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_FIRST) |-> (left_q == '0))
		else $error("leftover bits not cleared at group start");

	a_left_second: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_SECOND) |-> (left_q[3:2] == 2'b00))
		else $error("too many leftover bits after first byte");

endmodule

`default_nettype wire

// File: design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64e_pkg::entry_t push_entry,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output b64e_pkg::entry_t      head
);
	import b64e_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes queue entries and emits their characters one per cycle through an
// output register, while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      empty,
	input  wire b64e_pkg::entry_t          head,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [b64e_pkg::CHAR_W-1:0]    out_char,
	output logic                           out_last
);
	import b64e_pkg::*;

	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              phase_q;
	logic              load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !empty && (phase_q || !head.two);
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				phase_q <= !phase_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (phase_q) begin
				char_q <= to_char(head.sext1);
				last_q <= head.last;
			end else begin
				char_q <= to_char(head.sext0);
				last_q <= head.last && !head.two;
			end
		end
	end

	a_phase_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !empty)
		else $error("second character pending without a queued entry");

	a_phase_two: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head.two)
		else $error("second character pending for a one-character entry");

	a_pop_after_second: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !empty && !head.two) |-> pop)
		else $error("one-character entry not retired");

endmodule

`default_nettype wire

// File: design/bcrypt_radix64_encoder.sv
// ----------------------------------------------------------------------------
// bcrypt_radix64_encoder
// Unpadded radix-64 encoder with the bcrypt alphabet "./A-Za-z0-9".
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel, one per request, with s_axis_tlast on
// the final byte of a stream. Characters leave on the m_axis channel as
// 7-bit ASCII, one per request, with m_axis_tlast on the final character.
// A byte yields one character at group positions 0 and 1 and two at
// position 2; a final byte at position 0 or 1 adds one flush character.
// The first character of a byte is written into the queue and then into the
// output register before it appears on m_axis.
// The back end emits one character per cycle while m_axis_tready is high, so
// a byte takes one or two characters of output bandwidth. The character rate
// of the output register sets the byte rate. A two-entry queue decouples
// the byte side from the character side, so s_axis_tready stays high while
// the output register waits for m_axis_tready and the queue has room.
// Reset clears the group position, the leftover bits, the queue and the
// output valid. When the receiver stalls, the output holds its character,
// the queue fills, and then s_axis_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrypt_radix64_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tlast,  // final_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [6:0] out_char, [7] zero
	output logic            m_axis_tlast   // end_of_text
);
	import b64e_pkg::*;

	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	entry_t            push_entry;
	entry_t            head;
	logic [CHAR_W-1:0] out_char;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the bcrypt radix-64 encoder.
// ----------------------------------------------------------------------------
// A driver sends byte streams, one byte per request, with tlast on the final
// byte. A monitor checks every character against a queue of expected
// characters, which a local encoder model fills as bytes are accepted. The run
// has three phases of random idling: the receiver idles more than the sender,
// then the sender idles more than the receiver, then neither idles. A long
// receiver hold-off fills the block and stalls its input. Every phase ends
// only after all expected characters have arrived.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import b64e_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned PHASE_ITEMS   = 135;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              eot;
	} char_exp_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	byte_req_t pending_bytes[$];
	char_exp_t chars_due[$];

	string radix64_alphabet =
		"./ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

	group_pos_t       enc_pos   = POS_FIRST;
	logic [LEFT_W-1:0] enc_carry = '0;

	int unsigned send_idle_pct  = 26;
	int unsigned recv_idle_pct  = 75;
	int unsigned bytes_queued   = 0;
	int unsigned bytes_accepted = 0;
	int unsigned mismatches     = 0;
	int unsigned cycle_count    = 0;
	logic        hold_trigger   = 1'b0;
	logic        rx_hold        = 1'b0;

	bcrypt_radix64_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("MISMATCH %s: got %02h, want %02h, cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic expect_char(input logic [SEXTET_W-1:0] sextet, input logic eot);
		char_exp_t e;
		e.ch  = CHAR_W'(radix64_alphabet[sextet]);
		e.eot = eot;
		chars_due.push_back(e);
	endtask

	// Splits each byte into sextets, most significant bits first.
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		case (enc_pos)
			POS_SECOND: begin
				expect_char({enc_carry[1:0], b[7:4]}, 1'b0);
				enc_carry = b[3:0];
				enc_pos   = POS_THIRD;
				if (fin)
					expect_char({b[3:0], 2'b00}, 1'b1);
			end
			POS_THIRD: begin
				expect_char({enc_carry, b[7:6]}, 1'b0);
				expect_char(b[5:0], fin);
				enc_carry = '0;
				enc_pos   = POS_FIRST;
			end
			default: begin
				expect_char(b[7:2], 1'b0);
				enc_carry = {2'b00, b[1:0]};
				enc_pos   = POS_SECOND;
				if (fin)
					expect_char({b[1:0], 4'b0000}, 1'b1);
			end
		endcase
		if (fin) begin
			enc_pos   = POS_FIRST;
			enc_carry = '0;
		end
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic fin);
		byte_req_t r;
		r.data = data;
		r.fin  = fin;
		pending_bytes.push_back(r);
		bytes_queued++;
	endtask

	task automatic queue_random_stream(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			queue_byte(8'($urandom), i == len - 1);
	endtask

	task automatic queue_random_phase(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(12, 1);
			queue_random_stream(len);
			sent += len;
		end
	endtask

	task automatic wait_all_done();
		while (bytes_accepted != bytes_queued || chars_due.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Driver: a request stays on the bus until the block takes it.
	always @(posedge clk) begin
		byte_req_t r;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				encode_byte(s_axis_tdata, s_axis_tlast);
				bytes_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					r = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= r.data;
					s_axis_tlast  <= r.fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each character request with the oldest expectation.
	always @(posedge clk) begin
		char_exp_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (chars_due.size() == 0) begin
					report_mismatch("unexpected character", m_axis_tdata, 8'h00);
				end else begin
					want = chars_due.pop_front();
					if (m_axis_tdata !== {1'b0, want.ch})
						report_mismatch("character", m_axis_tdata, {1'b0, want.ch});
					if (m_axis_tlast !== want.eot)
						report_mismatch("end of text", {7'd0, m_axis_tlast},
							{7'd0, want.eot});
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		wait (hold_trigger);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Streams of one, two and more bytes, so that the final byte lands at
		// every group position, with all-zero and all-one bytes.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hff, 1'b1);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'hff, 1'b1);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'haa, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7f, 1'b1);
		queue_byte(8'hfb, 1'b0);
		queue_byte(8'hef, 1'b0);
		queue_byte(8'hbe, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h02, 1'b1);
		queue_random_phase(PHASE_ITEMS);
		wait_all_done();

		@(negedge clk);
		send_idle_pct = 75;
		recv_idle_pct = 26;
		queue_random_phase(PHASE_ITEMS);
		wait_all_done();

		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_trigger  = 1'b1;
		queue_random_phase(PHASE_ITEMS);
		wait_all_done();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (chars_due.size() != 0)
			report_mismatch("characters never arrived", 8'h00, 8'(chars_due.size()));
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: bcrypt_radix64_encoder.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/bcrypt_radix64_encoder.sv
tb/tb_top.sv
